@@ rtl/core/rrts_pkg.sv @@
// Package for the round-robin task timer scheduler.
// Holds the operation codes, timer constants and the transfer and control structs.
// Has no dependencies; every other file of the block imports it.
package rrts_pkg;

  localparam int NUM_TASKS_DEFAULT = 8;
  localparam int ID_W              = 3;
  localparam int ID_SPAN           = 8;
  localparam int TIMER_W           = 16;

  localparam logic [TIMER_W-1:0] TIMER_STOPPED = 16'hFFFF;
  localparam logic [TIMER_W-1:0] TIMER_ZERO    = 16'h0000;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_DISPATCH = 3'd1;
  localparam logic [2:0] OP_SLEEP    = 3'd2;
  localparam logic [2:0] OP_STOP     = 3'd3;
  localparam logic [2:0] OP_RUN      = 3'd4;
  localparam logic [2:0] OP_DELAY    = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic [ID_W-1:0]    task_index;
    logic [TIMER_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic            task_ready;
    logic            delay_pending;
  } rsp_t;

  typedef struct packed {
    logic               tick;
    logic               dispatch;
    logic               sleep;
    logic               stop;
    logic               run;
    logic [ID_W-1:0]    task_index;
    logic [TIMER_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/core/rrts_cell.sv @@
// One task cell of the scheduler: the task's countdown timer and its dispatch token.
// The token passes to the next cell on every dispatch. Depends on rrts_pkg.
module rrts_cell
  import rrts_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       token_in,
  output logic       token_out,
  output logic       zero
);

  localparam logic [ID_W-1:0] CELL_ID     = ID_W'(CELL_INDEX);
  localparam bit              ADDRESSABLE = (CELL_INDEX < ID_SPAN);
  localparam bit              FIRST       = (CELL_INDEX == 0);

  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic               token;
  logic               running;
  logic               addressed;

  assign addressed = ADDRESSABLE && (ctrl.task_index == CELL_ID);

  always_comb begin
    timer_next = timer;
    if (ctrl.stop && addressed) begin
      timer_next = TIMER_STOPPED;
    end else if (ctrl.run && addressed) begin
      timer_next = ctrl.value;
    end else if (ctrl.sleep && running) begin
      timer_next = ctrl.value;
    end else if (ctrl.tick && timer != TIMER_ZERO && timer != TIMER_STOPPED) begin
      timer_next = timer - TIMER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer   <= TIMER_ZERO;
      token   <= FIRST;
      running <= FIRST;
    end else begin
      timer <= timer_next;
      if (ctrl.dispatch) begin
        token   <= token_in;
        running <= token;
      end
    end
  end

  assign token_out = token;
  assign zero      = (timer == TIMER_ZERO);

endmodule

@@ rtl/core/round_robin_task_timer_scheduler.sv @@
// Top level of the round-robin task timer scheduler.
// Instantiates one rrts_cell per task in a ring and holds the pointer, delay counter and
// response register. Depends on rrts_pkg and rrts_cell.
//
// The block takes one command per clock cycle while not stalled and gives exactly one
// response per command, from an output register, in the cycle after its transfer. Every
// timer lives in its own cell, so one tick counts down at once all timers that are neither
// zero nor stopped; a dispatch hands the round-robin token to the next cell. A new command
// is taken unless the held response is stalled. There is no clearing pass after reset.
module round_robin_task_timer_scheduler
  import rrts_pkg::*;
#(
  parameter int NUM_TASKS = NUM_TASKS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PTR_W = (NUM_TASKS > ID_SPAN) ? $clog2(NUM_TASKS) : ID_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_TASKS - 1);

  logic                 accept;
  cell_ctrl_t           ctrl;
  logic [NUM_TASKS-1:0] token;
  logic [NUM_TASKS-1:0] zero;
  logic [PTR_W-1:0]     rr_pointer;
  logic [PTR_W-1:0]     rr_pointer_next;
  logic [TIMER_W-1:0]   delay_counter;
  logic [TIMER_W-1:0]   delay_counter_next;
  logic                 task_ready;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    ctrl            = '0;
    ctrl.task_index = cmd.task_index;
    ctrl.value      = cmd.value;
    if (accept) begin
      case (cmd.op)
        OP_TICK:     ctrl.tick     = 1'b1;
        OP_DISPATCH: ctrl.dispatch = 1'b1;
        OP_SLEEP:    ctrl.sleep    = 1'b1;
        OP_STOP:     ctrl.stop     = 1'b1;
        OP_RUN:      ctrl.run      = 1'b1;
        default:     ctrl.tick     = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    rrts_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .token_in (token[(i + NUM_TASKS - 1) % NUM_TASKS]),
      .token_out(token[i]),
      .zero     (zero[i])
    );
  end

  assign task_ready = |(token & zero);

  always_comb begin
    rr_pointer_next = rr_pointer;
    if (ctrl.dispatch) begin
      rr_pointer_next = (rr_pointer == PTR_LAST) ? '0 : rr_pointer + PTR_W'(1);
    end
  end

  always_comb begin
    delay_counter_next = delay_counter;
    if (accept && cmd.op == OP_DELAY) begin
      delay_counter_next = cmd.value;
    end else if (ctrl.tick && delay_counter != TIMER_ZERO) begin
      delay_counter_next = delay_counter - TIMER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_pointer    <= '0;
      delay_counter <= TIMER_ZERO;
      rsp_valid     <= 1'b0;
    end else begin
      rr_pointer    <= rr_pointer_next;
      delay_counter <= delay_counter_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.task_id       <= ctrl.dispatch ? rr_pointer[ID_W-1:0] : rr_pointer_next[ID_W-1:0];
      rsp.task_ready    <= ctrl.dispatch && task_ready;
      rsp.delay_pending <= (delay_counter_next != TIMER_ZERO);
    end
  end

endmodule

@@ tb/round_robin_task_timer_scheduler_test.sv @@
// Self-checking testbench for the round-robin task timer scheduler.
// Runs a directed table and then random commands, checking every response against the table's
// typed expected values or its own scheduler model. Depends on rrts_pkg and the round_robin_task_timer_scheduler RTL.
module round_robin_task_timer_scheduler_test
  import rrts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         N_TASKS    = NUM_TASKS_DEFAULT;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int         RAND_ITEMS = 650;

  typedef struct packed {
    logic [2:0]         op;
    logic [ID_W-1:0]    idx;
    logic [TIMER_W-1:0] val;
    logic               typed;
    logic [ID_W-1:0]    id;
    logic               rdy;
    logic               pend;
  } row_t;

  typedef struct packed {
    logic typed;
    rsp_t r;
  } note_t;

  localparam row_t PLAN [0:23] = '{
    '{OP_TICK,     3'd0, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 3'd0, 1'b1, 1'b0},
    '{OP_SLEEP,    3'd0, 16'hFFFF, 1'b1, 3'd1, 1'b0, 1'b0},
    '{OP_DELAY,    3'd0, 16'hFFFF, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_RUN,      3'd7, 16'h0001, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_STOP,     3'd1, 16'h0000, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_SPARE_A,  3'd0, 16'h0000, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_SPARE_B,  3'd7, 16'hFFFF, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b1, 3'd1, 1'b0, 1'b1},
    '{OP_TICK,     3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_SLEEP,    3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DELAY,    3'd0, 16'h0001, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_TICK,     3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_RUN,      3'd2, 16'h0002, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_RUN,      3'd3, 16'hFFFE, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_DISPATCH, 3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_SLEEP,    3'd0, 16'h8000, 1'b0, 3'd0, 1'b0, 1'b0},
    '{OP_TICK,     3'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0}
  };

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int tx_idle = 32;
  int rx_idle = 88;
  int fails   = 0;

  rsp_t  due_q [$];
  note_t notes [$];

  logic [TIMER_W-1:0] timer_left [N_TASKS] = '{default: '0};
  int unsigned        rr_next    = 0;
  int unsigned        cur_task   = 0;
  logic [TIMER_W-1:0] delay_left = '0;

  round_robin_task_timer_scheduler #(.NUM_TASKS(N_TASKS)) uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rx_idle);
  end

  function automatic rsp_t schedule_step(input cmd_t c);
    rsp_t r;
    r = '0;
    case (c.op)
      OP_TICK: begin
        for (int t = 0; t < N_TASKS; t++) begin
          if (timer_left[t] != TIMER_ZERO && timer_left[t] != TIMER_STOPPED) begin
            timer_left[t] = timer_left[t] - 16'd1;
          end
        end
        if (delay_left != TIMER_ZERO) begin
          delay_left = delay_left - 16'd1;
        end
      end
      OP_SLEEP: timer_left[cur_task] = c.value;
      OP_STOP: begin
        if (c.task_index < N_TASKS) timer_left[c.task_index] = TIMER_STOPPED;
      end
      OP_RUN: begin
        if (c.task_index < N_TASKS) timer_left[c.task_index] = c.value;
      end
      OP_DELAY: delay_left = c.value;
      default: ;
    endcase
    r.task_id = ID_W'(rr_next);
    if (c.op == OP_DISPATCH) begin
      r.task_ready = (timer_left[rr_next] == TIMER_ZERO);
      cur_task     = rr_next;
      rr_next      = (rr_next + 1) % N_TASKS;
    end
    r.delay_pending = (delay_left != TIMER_ZERO);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t  want;
    note_t nt;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_q.size() == 0) begin
          $error("response transfer with no command outstanding: %p", rsp);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (rsp.task_id !== want.task_id) begin
            $error("task_id: expected %0d, got %0d", want.task_id, rsp.task_id);
            fails++;
          end
          if (rsp.task_ready !== want.task_ready) begin
            $error("task_ready: expected %0d, got %0d", want.task_ready, rsp.task_ready);
            fails++;
          end
          if (rsp.delay_pending !== want.delay_pending) begin
            $error("delay_pending: expected %0d, got %0d", want.delay_pending,
                   rsp.delay_pending);
            fails++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        nt   = notes.pop_front();
        want = schedule_step(cmd);
        due_q.push_back(nt.typed ? nt.r : want);
      end
    end
  end

  task automatic offer(input cmd_t c, input logic typed, input rsp_t r);
    note_t nt;
    nt.typed = typed;
    nt.r     = r;
    while ($urandom_range(99) < tx_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    notes.push_back(nt);
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  initial begin
    cmd_t c;
    rsp_t r;
    int   k;
    int   j;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PLAN[i]) begin
      c.op              = PLAN[i].op;
      c.task_index      = PLAN[i].idx;
      c.value           = PLAN[i].val;
      r.task_id         = PLAN[i].id;
      r.task_ready      = PLAN[i].rdy;
      r.delay_pending   = PLAN[i].pend;
      offer(c, PLAN[i].typed, r);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 32 : (ph == 1) ? 88 : 0;
      rx_idle = (ph == 0) ? 88 : (ph == 1) ? 32 : 0;
      // Hold the command side until every response of the previous phase is back.
      while (due_q.size() != 0) begin
        cmd_valid <= 1'b0;
        @(negedge clk);
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        k            = $urandom_range(99);
        j            = $urandom_range(9);
        c.task_index = ID_W'($urandom_range(7));
        if (k < 30) c.op = OP_TICK;
        else if (k < 55) c.op = OP_DISPATCH;
        else if (k < 70) c.op = OP_SLEEP;
        else if (k < 76) c.op = OP_STOP;
        else if (k < 88) c.op = OP_RUN;
        else if (k < 96) c.op = OP_DELAY;
        else c.op = k[0] ? OP_SPARE_A : OP_SPARE_B;
        if (j < 6) c.value = TIMER_W'($urandom_range(12));
        else if (j < 8) c.value = TIMER_W'($urandom);
        else if (j == 8) c.value = TIMER_STOPPED;
        else c.value = TIMER_STOPPED - 16'd1;
        offer(c, 1'b0, '0);
      end
    end

    cmd_valid <= 1'b0;
    while (due_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fails == 0 && due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
